### rtl/chtm_pkg.sv
`default_nettype none
package chtm_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  // Request kinds.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_REPLY  = 2'd1;
  localparam logic [1:0] REQ_ADD    = 2'd2;
  localparam logic [1:0] REQ_REMOVE = 2'd3;

  // Result codes.
  localparam logic [3:0] EV_ADDED     = 4'd0;
  localparam logic [3:0] EV_DUPLICATE = 4'd1;
  localparam logic [3:0] EV_FULL      = 4'd2;
  localparam logic [3:0] EV_SEND_BEAT = 4'd3;
  localparam logic [3:0] EV_TIMED_OUT = 4'd4;
  localparam logic [3:0] EV_BEAT_OK   = 4'd5;
  localparam logic [3:0] EV_REJECTED  = 4'd6;
  localparam logic [3:0] EV_UNKNOWN   = 4'd7;
  localparam logic [3:0] EV_REMOVED   = 4'd8;
  localparam logic [3:0] EV_NOT_FOUND = 4'd9;
  localparam logic [3:0] EV_TICK_DONE = 4'd10;

  // Configuration register indexes.
  localparam logic [7:0] CFG_INTERVAL = 8'd0;
  localparam logic [7:0] CFG_RETRIES  = 8'd1;
  localparam logic [7:0] CFG_TIMEOUT  = 8'd2;
  localparam logic [7:0] CFG_HIGHEST  = 8'd3;

  localparam logic [15:0] NULL_ID = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] client_id;
    logic [15:0] delta_ms;
  } req_t;

  typedef struct packed {
    logic [3:0]   event_res;
    logic [15:0]  out_client_id;
    logic [30:0]  ping_ms;
    logic signed [31:0] stamp_ms;
    logic         last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADV, ST_FOLD, ST_TSCAN, ST_TDONE, ST_SCAN, ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic advance;
    logic fold_step;
    logic tick_step;
    logic scan_step;
    logic finish;
    logic tick_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fold_needed;
    logic idx_last;
  } stat_t;

endpackage
`default_nettype wire

### rtl/chtm_ctrl.sv
`default_nettype none
module chtm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     req_type,
  input  wire chtm_pkg::stat_t stat,
  output chtm_pkg::cmd_t      cmd,
  output logic                busy
);
  import chtm_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (req_type == REQ_TICK) ? ST_ADV : ST_SCAN;
        end
      end
      ST_ADV:    state_next = stat.fold_needed ? ST_FOLD : ST_TSCAN;
      ST_FOLD:   state_next = stat.idx_last ? ST_TSCAN : ST_FOLD;
      ST_TSCAN:  state_next = stat.idx_last ? ST_TDONE : ST_TSCAN;
      ST_TDONE:  state_next = ST_IDLE;
      ST_SCAN:   state_next = stat.idx_last ? ST_FINISH : ST_SCAN;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_ADV:    cmd.advance   = 1'b1;
      ST_FOLD:   cmd.fold_step = 1'b1;
      ST_TSCAN:  cmd.tick_step = 1'b1;
      ST_TDONE:  cmd.tick_done = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_FINISH: cmd.finish    = 1'b1;
      default:   busy          = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

### rtl/chtm_dp.sv
`default_nettype none
module chtm_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire chtm_pkg::req_t req,
  input  wire chtm_pkg::cmd_t cmd,
  output chtm_pkg::stat_t    stat,
  input  wire logic          cfg_valid,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output logic               res_valid,
  output chtm_pkg::res_t     res
);
  import chtm_pkg::*;

  // Configuration.
  logic [15:0] interval;
  logic [7:0]  retries;
  logic [30:0] timeout;
  logic [30:0] highest;

  // Table.
  logic [MAX_CLIENTS-1:0] valid;
  logic [15:0] ent_id    [MAX_CLIENTS];
  logic [31:0] ent_ip    [MAX_CLIENTS];
  logic [15:0] ent_port  [MAX_CLIENTS];
  logic [31:0] last_beat [MAX_CLIENTS];
  logic [31:0] beat_sent [MAX_CLIENTS];
  logic        awaiting  [MAX_CLIENTS];
  logic [7:0]  retry     [MAX_CLIENTS];

  logic [31:0] server_time;
  logic [15:0] next_id;
  req_t        rq;
  logic [IDX_W-1:0] idx;

  // Results of the search pass.
  logic found_a, found_f, found_i;
  logic [IDX_W-1:0] a_idx, f_idx, i_idx;

  assign stat.idx_last = (idx == IDX_W'(MAX_CLIENTS - 1));

  // Time advance.
  logic [31:0] st_sum;
  assign st_sum           = server_time + {16'b0, rq.delta_ms};
  assign stat.fold_needed = st_sum[31];

  // Fold of one stored beat time.
  logic [31:0] fold_d;
  assign fold_d = last_beat[idx] - {1'b0, highest};

  // Per-slot tick evaluation.
  logic [31:0] elapsed;
  logic [24:0] prod;
  logic ge_int, ge_to, ge_prod, retry_over, t_live, t_drop, t_send;
  assign elapsed    = server_time - last_beat[idx];
  assign prod       = interval * ({1'b0, retry[idx]} + 9'd1);
  assign ge_int     = $signed({elapsed[31], elapsed}) >= $signed({17'b0, interval});
  assign ge_to      = $signed({elapsed[31], elapsed}) >= $signed({2'b0, timeout});
  assign ge_prod    = $signed({elapsed[31], elapsed}) >= $signed({8'b0, prod});
  assign retry_over = retry[idx] > retries;
  assign t_live     = valid[idx] && ge_int;
  assign t_drop     = t_live && (ge_to || retry_over);
  assign t_send     = t_live && !t_drop && (!awaiting[idx] || ge_prod);

  // Per-slot search hits.
  logic [15:0] id_key;
  logic hit_a, hit_i;
  assign id_key = (rq.req_type == REQ_REMOVE) ? rq.client_id : next_id;
  assign hit_a  = valid[idx] && ent_ip[idx] == rq.peer_ip && ent_port[idx] == rq.peer_port;
  assign hit_i  = valid[idx] && ent_id[idx] == id_key;

  // Ping for an accepted reply.
  logic [31:0] ping_raw;
  assign ping_raw = server_time - beat_sent[a_idx];

  // Result selection.
  logic emit;
  res_t emit_val;
  always_comb begin
    emit     = 1'b0;
    emit_val = '0;
    if (cmd.tick_step) begin
      emit_val.out_client_id = ent_id[idx];
      if (t_drop) begin
        emit               = 1'b1;
        emit_val.event_res = EV_TIMED_OUT;
      end else if (t_send) begin
        emit               = 1'b1;
        emit_val.event_res = EV_SEND_BEAT;
        emit_val.stamp_ms  = server_time;
      end
    end else if (cmd.tick_done) begin
      emit               = 1'b1;
      emit_val.event_res = EV_TICK_DONE;
      emit_val.stamp_ms  = server_time;
      emit_val.last      = 1'b1;
    end else if (cmd.finish) begin
      emit          = 1'b1;
      emit_val.last = 1'b1;
      case (rq.req_type)
        REQ_REPLY: begin
          if (!found_a) begin
            emit_val.event_res = EV_UNKNOWN;
          end else if (!awaiting[a_idx]) begin
            emit_val.event_res     = EV_REJECTED;
            emit_val.out_client_id = ent_id[a_idx];
          end else begin
            emit_val.event_res     = EV_BEAT_OK;
            emit_val.out_client_id = ent_id[a_idx];
            emit_val.ping_ms       = ping_raw[31] ? 31'd0 : ping_raw[30:0];
          end
        end
        REQ_ADD: begin
          if (found_a || !found_f) begin
            emit_val.event_res     = found_a ? EV_DUPLICATE : EV_FULL;
            emit_val.out_client_id = NULL_ID;
          end else begin
            emit_val.event_res     = found_i ? EV_DUPLICATE : EV_ADDED;
            emit_val.out_client_id = next_id;
          end
        end
        REQ_REMOVE: begin
          emit_val.event_res     = found_i ? EV_REMOVED : EV_NOT_FOUND;
          emit_val.out_client_id = rq.client_id;
        end
        default: emit_val.event_res = EV_TICK_DONE;
      endcase
    end
  end

  // Control state: configuration, valid bits, time, ids, index, output strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      interval    <= 16'd1000;
      retries     <= 8'd5;
      timeout     <= 31'd10000;
      highest     <= 31'h7FFFFFFF;
      valid       <= '0;
      server_time <= '0;
      next_id     <= '0;
      idx         <= '0;
      res_valid   <= 1'b0;
      found_a     <= 1'b0;
      found_f     <= 1'b0;
      found_i     <= 1'b0;
    end else begin
      res_valid <= emit;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INTERVAL: interval <= cfg_data[15:0];
          CFG_RETRIES:  retries  <= cfg_data[7:0];
          CFG_TIMEOUT:  timeout  <= cfg_data[30:0];
          CFG_HIGHEST:  highest  <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (cmd.latch) begin
        idx     <= '0;
        found_a <= 1'b0;
        found_f <= 1'b0;
        found_i <= 1'b0;
      end
      if (cmd.fold_step || cmd.tick_step || cmd.scan_step) begin
        idx <= stat.idx_last ? '0 : idx + 1'b1;
      end
      if (cmd.advance) begin
        server_time <= st_sum[31] ? st_sum - {1'b0, highest} : st_sum;
      end
      if (cmd.tick_step && t_drop) begin
        valid[idx] <= 1'b0;
      end
      // First hits of the search pass.
      if (cmd.scan_step) begin
        if (hit_a && !found_a) begin
          found_a <= 1'b1;
        end
        if (!valid[idx] && !found_f) begin
          found_f <= 1'b1;
        end
        if (hit_i && !found_i) begin
          found_i <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (rq.req_type == REQ_ADD && !found_a && found_f) begin
          next_id <= next_id + 16'd1;
          if (!found_i) begin
            valid[f_idx] <= 1'b1;
          end
        end
        if (rq.req_type == REQ_REMOVE && found_i) begin
          valid[i_idx] <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_val;
    end
    if (cmd.latch) begin
      rq <= req;
    end
    if (cmd.scan_step) begin
      if (hit_a && !found_a) begin
        a_idx <= idx;
      end
      if (!valid[idx] && !found_f) begin
        f_idx <= idx;
      end
      if (hit_i && !found_i) begin
        i_idx <= idx;
      end
    end
    if (cmd.fold_step) begin
      last_beat[idx] <= fold_d[31] ? (32'd0 - fold_d) : fold_d;
    end
    if (cmd.tick_step && t_send) begin
      if (retry[idx] == 8'd0) begin
        beat_sent[idx] <= server_time;
      end
      awaiting[idx] <= 1'b1;
      if (retry[idx] != 8'hFF) begin
        retry[idx] <= retry[idx] + 8'd1;
      end
    end
    if (cmd.finish) begin
      if (rq.req_type == REQ_REPLY && found_a && awaiting[a_idx]) begin
        last_beat[a_idx] <= server_time;
        awaiting[a_idx]  <= 1'b0;
        retry[a_idx]     <= 8'd0;
      end
      if (rq.req_type == REQ_ADD && !found_a && found_f && !found_i) begin
        ent_id[f_idx]    <= next_id;
        ent_ip[f_idx]    <= rq.peer_ip;
        ent_port[f_idx]  <= rq.peer_port;
        last_beat[f_idx] <= server_time;
        beat_sent[f_idx] <= server_time;
        awaiting[f_idx]  <= 1'b0;
        retry[f_idx]     <= 8'd0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/client_heartbeat_timeout_monitor_unit.sv
`default_nettype none
// Heartbeat and timeout monitor for a table of up to MAX_CLIENTS peers.
// A request is taken when start is high and busy is low. req carries the
// kind (tick, heartbeat reply, add, remove by id) and its fields.
// Results leave on res, each valid for exactly one cycle with res_valid
// high; the receiver cannot stall, so none is held back. The last result
// of a request has res.last set.
// Configuration writes use cfg_valid/cfg_ready (ready always high) with a
// register index and data; write only while the block is idle.
// Sequence: reply, add and remove search every slot, one per cycle, and then
// act in a final step. A tick advances the server time, scans every slot
// and then reports completion; when the server time folds back, every
// stored beat time is first adjusted in a pass of its own. Each result
// is registered and appears in the cycle after its slot is examined or
// its request acts.
// Reset clears the table valid bits, the server time, the id counter and
// restores the register defaults; it is synchronous.
module client_heartbeat_timeout_monitor_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire chtm_pkg::req_t req,
  output logic                res_valid,
  output chtm_pkg::res_t      res,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [7:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);
  import chtm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  chtm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  chtm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule
`default_nettype wire

### tb/tb_client_heartbeat_timeout_monitor_unit.sv
`default_nettype none
import chtm_pkg::*;

// Expected peer events, predicted from a private copy of the peer table.
class peer_event_board;
  logic [15:0] interval;
  logic [7:0]  retries;
  logic [30:0] timeout;
  logic [30:0] highest;
  bit          live [MAX_CLIENTS];
  logic [15:0] id_of [MAX_CLIENTS];
  logic [31:0] ip_of [MAX_CLIENTS];
  logic [15:0] port_of [MAX_CLIENTS];
  logic [31:0] beat_at [MAX_CLIENTS];
  logic [31:0] sent_at [MAX_CLIENTS];
  bit          waiting [MAX_CLIENTS];
  logic [7:0]  tries [MAX_CLIENTS];
  logic [31:0] now;
  logic [15:0] id_counter;
  res_t        pending[$];
  int          errors;

  function void clear();
    interval = 16'd1000;
    retries = 8'd5;
    timeout = 31'd10000;
    highest = 31'h7FFFFFFF;
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      live[i] = 0;
      beat_at[i] = '0;
      sent_at[i] = '0;
      waiting[i] = 0;
      tries[i] = '0;
      id_of[i] = '0;
      ip_of[i] = '0;
      port_of[i] = '0;
    end
    now = '0;
    id_counter = '0;
    pending.delete();
    errors = 0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [31:0] data);
    case (idx)
      CFG_INTERVAL: interval = data[15:0];
      CFG_RETRIES:  retries = data[7:0];
      CFG_TIMEOUT:  timeout = data[30:0];
      CFG_HIGHEST:  highest = data[30:0];
      default: ;
    endcase
  endfunction

  function void push(logic [3:0] ev, logic [15:0] id, logic [30:0] ping,
                     logic [31:0] stamp, bit fin);
    res_t r;
    r.event_res = ev;
    r.out_client_id = id;
    r.ping_ms = ping;
    r.stamp_ms = stamp;
    r.last = fin;
    pending.push_back(r);
  endfunction

  function int find_peer(logic [31:0] ip, logic [15:0] port);
    for (int i = 0; i < MAX_CLIENTS; i++)
      if (live[i] && ip_of[i] == ip && port_of[i] == port) return i;
    return -1;
  endfunction

  // Note an accepted request and queue the events it must produce.
  function void note_request(req_t q);
    int s;
    int slot;
    logic [31:0] d;
    longint el;
    longint p;
    bit clash;
    s = -1;
    slot = -1;
    clash = 0;
    case (q.req_type)
      REQ_TICK: begin
        now = now + {16'd0, q.delta_ms};
        if (now[31]) begin
          now = now - {1'b0, highest};
          for (int i = 0; i < MAX_CLIENTS; i++) begin
            d = beat_at[i] - {1'b0, highest};
            if (d[31]) d = -d;
            beat_at[i] = d;
          end
        end
        for (int i = 0; i < MAX_CLIENTS; i++) begin
          if (!live[i]) continue;
          el = longint'($signed(now - beat_at[i]));
          if (el < longint'(interval)) continue;
          if (el >= longint'(timeout) || tries[i] > retries) begin
            push(EV_TIMED_OUT, id_of[i], '0, '0, 0);
            live[i] = 0;
            continue;
          end
          if (!waiting[i] || el >= longint'(interval) * (longint'(tries[i]) + 1)) begin
            push(EV_SEND_BEAT, id_of[i], '0, now, 0);
            if (tries[i] == 0) sent_at[i] = now;
            waiting[i] = 1;
            if (tries[i] != 8'hFF) tries[i]++;
          end
        end
        push(EV_TICK_DONE, '0, '0, now, 1);
      end
      REQ_REPLY: begin
        s = find_peer(q.peer_ip, q.peer_port);
        if (s < 0) push(EV_UNKNOWN, '0, '0, '0, 1);
        else if (!waiting[s]) push(EV_REJECTED, id_of[s], '0, '0, 1);
        else begin
          p = longint'($signed(now - sent_at[s]));
          if (p < 0) p = 0;
          beat_at[s] = now;
          waiting[s] = 0;
          tries[s] = '0;
          push(EV_BEAT_OK, id_of[s], p[30:0], '0, 1);
        end
      end
      REQ_ADD: begin
        if (find_peer(q.peer_ip, q.peer_port) >= 0) push(EV_DUPLICATE, NULL_ID, '0, '0, 1);
        else begin
          for (int i = MAX_CLIENTS - 1; i >= 0; i--) if (!live[i]) slot = i;
          if (slot < 0) push(EV_FULL, NULL_ID, '0, '0, 1);
          else begin
            for (int i = 0; i < MAX_CLIENTS; i++)
              if (live[i] && id_of[i] == id_counter) clash = 1;
            if (clash) push(EV_DUPLICATE, id_counter, '0, '0, 1);
            else begin
              live[slot] = 1;
              id_of[slot] = id_counter;
              ip_of[slot] = q.peer_ip;
              port_of[slot] = q.peer_port;
              beat_at[slot] = now;
              sent_at[slot] = now;
              waiting[slot] = 0;
              tries[slot] = '0;
              push(EV_ADDED, id_counter, '0, '0, 1);
            end
            id_counter = id_counter + 16'd1;
          end
        end
      end
      default: begin
        for (int i = 0; i < MAX_CLIENTS; i++)
          if (s < 0 && live[i] && id_of[i] == q.client_id) s = i;
        if (s >= 0) begin
          live[s] = 0;
          push(EV_REMOVED, q.client_id, '0, '0, 1);
        end else push(EV_NOT_FOUND, q.client_id, '0, '0, 1);
      end
    endcase
  endfunction

  // Compare one transfer from the block with the oldest expected event.
  function void check_event(res_t got);
    res_t want;
    if (pending.size() == 0) begin
      $error("unexpected result event_res=%0d", got.event_res);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.event_res !== want.event_res) begin
      $error("event_res expected %0d actual %0d", want.event_res, got.event_res);
      errors++;
    end
    if (got.out_client_id !== want.out_client_id) begin
      $error("out_client_id expected %0d actual %0d", want.out_client_id, got.out_client_id);
      errors++;
    end
    if (got.ping_ms !== want.ping_ms) begin
      $error("ping_ms expected %0d actual %0d", want.ping_ms, got.ping_ms);
      errors++;
    end
    if (got.stamp_ms !== want.stamp_ms) begin
      $error("stamp_ms expected %0d actual %0d", want.stamp_ms, got.stamp_ms);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last expected %0d actual %0d", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_client_heartbeat_timeout_monitor_unit;
  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        res_valid;
  res_t        res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;
  int          gap_pct;
  int          cycles;
  logic [31:0] peer_ips [8];
  logic [15:0] peer_ports [8];
  peer_event_board board;

  client_heartbeat_timeout_monitor_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .res_valid(res_valid), .res(res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Check every result transfer at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && res_valid) board.check_event(res);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Start stays high after a transfer; the next request or drain decides.
  task automatic send(req_t q);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= q;
    do @(posedge clk); while (busy);
    board.note_request(q);
  endtask

  // Stop sending, let the block drain, then allow for a trailing scan.
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  function automatic req_t mk(logic [1:0] kind, logic [31:0] ip, logic [15:0] port,
                              logic [15:0] id, logic [15:0] delta);
    req_t q;
    q.req_type = kind;
    q.peer_ip = ip;
    q.peer_port = port;
    q.client_id = id;
    q.delta_ms = delta;
    return q;
  endfunction

  // Random request, biased toward a small pool of known peers.
  function automatic req_t rand_req();
    int k;
    logic [31:0] ip;
    logic [15:0] port;
    k = $urandom_range(7);
    ip = peer_ips[k];
    port = peer_ports[k];
    if ($urandom_range(9) == 0) begin
      ip = $urandom;
      port = 16'($urandom);
    end
    case ($urandom_range(9))
      0, 1, 2, 3: return mk(REQ_TICK, $urandom, 16'($urandom), 16'($urandom),
                            ($urandom_range(9) == 0) ? 16'($urandom) :
                            16'($urandom_range(1500)));
      4, 5: return mk(REQ_REPLY, ip, port, 16'($urandom), 16'($urandom));
      6, 7: return mk(REQ_ADD, ip, port, 16'($urandom), 16'($urandom));
      default: return mk(REQ_REMOVE, $urandom, 16'($urandom),
                         ($urandom_range(3) == 0) ? 16'($urandom) :
                         16'($urandom_range(20)), 16'($urandom));
    endcase
  endfunction

  initial begin
    board = new();
    board.clear();
    cycles = 0;
    rst = 1;
    start = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 0;
    for (int i = 0; i < 8; i++) begin
      peer_ips[i] = $urandom;
      peer_ports[i] = 16'($urandom);
    end
    peer_ips[0] = '0;
    peer_ports[0] = '0;
    peer_ips[1] = '1;
    peer_ports[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: adds, duplicates, replies, removes, ticks up to timeout.
    send(mk(REQ_ADD, peer_ips[0], peer_ports[0], '0, '0));
    send(mk(REQ_ADD, peer_ips[1], peer_ports[1], '1, '1));
    send(mk(REQ_ADD, peer_ips[1], peer_ports[1], '0, '0));
    send(mk(REQ_REPLY, peer_ips[0], peer_ports[0], '0, '0));
    send(mk(REQ_REPLY, 32'h5555AAAA, 16'hA5A5, '0, '0));
    send(mk(REQ_TICK, '0, '0, '0, 16'd1000));
    send(mk(REQ_TICK, '0, '0, '0, 16'd999));
    send(mk(REQ_TICK, '0, '0, '0, 16'd1001));
    send(mk(REQ_REPLY, peer_ips[0], peer_ports[0], '0, '0));
    send(mk(REQ_TICK, '0, '0, '0, 16'hFFFF));
    send(mk(REQ_REMOVE, '0, '0, 16'd1, '0));
    send(mk(REQ_REMOVE, '0, '0, 16'hFFFF, '0));
    for (int i = 0; i < MAX_CLIENTS + 1; i++)
      send(mk(REQ_ADD, 32'h0A000000 + i, 16'(i), '0, '0));
    drain();

    // Extreme settings: a tiny interval and no retries drop silent peers.
    write_reg(CFG_INTERVAL, 32'd1);
    write_reg(CFG_RETRIES, 32'd0);
    write_reg(CFG_TIMEOUT, 32'h7FFFFFFF);
    write_reg(CFG_HIGHEST, 32'd1);
    send(mk(REQ_TICK, '0, '0, '0, 16'd1));
    send(mk(REQ_TICK, '0, '0, '0, 16'd1));
    drain();

    // Large ticks with the widest interval and retry range.
    write_reg(CFG_HIGHEST, 32'h7FFFFFFF);
    write_reg(CFG_RETRIES, 32'd255);
    write_reg(CFG_INTERVAL, 32'd65535);
    for (int i = 0; i < 8; i++)
      send(mk(REQ_TICK, '0, '0, '0, 16'hFFFF));
    drain();

    // Random phases with different settings and idling.
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 19 : (ph == 1) ? 54 : 0;
      write_reg(CFG_INTERVAL, (ph == 2) ? 32'd65535 : 32'($urandom_range(100, 2000)));
      write_reg(CFG_RETRIES, (ph == 1) ? 32'd255 : 32'($urandom_range(0, 6)));
      write_reg(CFG_TIMEOUT, (ph == 0) ? 32'd1 : 32'($urandom_range(3000, 20000)));
      write_reg(CFG_HIGHEST, (ph == 2) ? 32'd1 : 32'($urandom));
      for (int n = 0; n < 100; n++) begin
        send(rand_req());
        if (n == 50) drain();
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
